FILE: design/percore_priority_run_queue_assert.svh
// Assertion helpers for the run queue. Every check is clocked on clk_i and
// is held off while rst_ni is low.
`ifndef PERCORE_PRIORITY_RUN_QUEUE_ASSERT_SVH
`define PERCORE_PRIORITY_RUN_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPRQ_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPRQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/pprq_pkg.sv
package pprq_pkg;

  localparam int unsigned CoresDef   = 4;
  localparam int unsigned LevelsDef  = 32;
  localparam int unsigned ThreadsDef = 64;

  localparam int unsigned TidW      = 6;
  localparam int unsigned PrioReqW  = 8;
  localparam int unsigned AffW      = 5;
  localparam int unsigned CoreW     = 2;
  localparam int unsigned PrioW     = 5;
  localparam int unsigned IsoW      = 4;
  localparam int unsigned ActW      = 3;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned CmdqDepth = 2;

  localparam logic [IsoW-1:0] IsoReset = 4'd0;
  localparam logic [ActW-1:0] ActReset = 3'd4;

  typedef enum logic {
    OpAdd  = 1'b0,
    OpPick = 1'b1
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgIsolated = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgActive   = 1'b1;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic             drop;
    logic [TidW-1:0]  tid;
    logic [PrioW-1:0] prio;
    logic [CoreW-1:0] core;
  } cmd_t;

endpackage

FILE: design/pprq_ram.sv
module pprq_ram import pprq_pkg::*; #(
  parameter int unsigned WIDTH = TidW,
  parameter int unsigned DEPTH = ThreadsDef,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pprq_front.sv
module pprq_front import pprq_pkg::*; #(
  parameter int unsigned CORES           = CoresDef,
  parameter int unsigned PRIORITY_LEVELS = LevelsDef,
  parameter int unsigned THREADS         = ThreadsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [TidW-1:0]            thread_id_i,
  input  logic signed [PrioReqW-1:0] priority_req_i,
  input  logic signed [AffW-1:0]     affinity_i,
  input  logic                       normal_policy_i,
  input  logic [CoreW-1:0]           core_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output cmd_t                       q_data_o
);

  logic [IsoW-1:0]  isolated_q, isolated_d;
  logic [ActW-1:0]  active_q, active_d;
  logic [CoreW-1:0] rr_q, rr_d;

  logic [ActW-1:0]  rr_count;
  logic [CoreW-1:0] rr_cur;
  logic [CoreW-1:0] rr_nxt;
  logic             aff_ok;
  logic [CoreW-1:0] cpu_pick;
  logic [CoreW-1:0] cpu_final;
  logic [PrioW-1:0] prio_clamped;
  logic             drop;
  logic             xfer;
  op_e              op;

  assign op = op_e'(kind_i);

  always_comb begin
    isolated_d = isolated_q;
    active_d   = active_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIsolated: isolated_d = cfg_wdata_i[IsoW-1:0] | IsoReset;
        CfgActive:   active_d   = cfg_wdata_i[ActW-1:0];
        default:     ;
      endcase
    end
  end

  // Round-robin span, held to the range 1 up to CORES.
  always_comb begin
    if (active_q == '0) begin
      rr_count = ActW'(1);
    end else if (active_q > ActW'(CORES)) begin
      rr_count = ActW'(CORES);
    end else begin
      rr_count = active_q;
    end
    rr_cur = ({1'b0, rr_q} >= rr_count) ? '0 : rr_q;
    rr_nxt = (({1'b0, rr_cur} + ActW'(1)) >= rr_count) ? '0 : (rr_cur + CoreW'(1));
  end

  always_comb begin
    if (priority_req_i[PrioReqW-1]) begin
      prio_clamped = '0;
    end else if (priority_req_i[PrioReqW-2:0] >= (PrioReqW-1)'(PRIORITY_LEVELS)) begin
      prio_clamped = PrioW'(PRIORITY_LEVELS - 1);
    end else begin
      prio_clamped = priority_req_i[PrioW-1:0];
    end
  end

  assign aff_ok    = !affinity_i[AffW-1] && (affinity_i[AffW-2:0] < (AffW-1)'(CORES));
  assign cpu_pick  = aff_ok ? affinity_i[CoreW-1:0] : rr_cur;
  assign cpu_final = (isolated_q[cpu_pick] && normal_policy_i) ? '0 : cpu_pick;
  assign drop      = ({1'b0, thread_id_i} >= (TidW+1)'(THREADS));

  assign in_ready_o = !q_full_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign q_push_o   = xfer;

  always_comb begin
    q_data_o.op   = op;
    q_data_o.drop = (op == OpAdd) && drop;
    q_data_o.tid  = thread_id_i;
    q_data_o.prio = prio_clamped;
    q_data_o.core = (op == OpAdd) ? cpu_final : core_i;
  end

  always_comb begin
    rr_d = rr_q;
    if (xfer && (op == OpAdd) && !drop && !aff_ok) begin
      rr_d = rr_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isolated_q <= IsoReset;
      active_q   <= ActReset;
      rr_q       <= '0;
    end else begin
      isolated_q <= isolated_d;
      active_q   <= active_d;
      rr_q       <= rr_d;
    end
  end

endmodule

FILE: design/pprq_cmdq.sv
module pprq_cmdq import pprq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned AW = (CmdqDepth > 1) ? $clog2(CmdqDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdqDepth + 1);

  cmd_t            mem_q [CmdqDepth];
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(CmdqDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(CmdqDepth - 1)) ? '0 : (wptr_q + AW'(1));
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(CmdqDepth - 1)) ? '0 : (rptr_q + AW'(1));
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: design/pprq_back.sv
module pprq_back import pprq_pkg::*; #(
  parameter int unsigned CORES           = CoresDef,
  parameter int unsigned PRIORITY_LEVELS = LevelsDef,
  parameter int unsigned THREADS         = ThreadsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             q_data_i,
  output logic             q_pop_o,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TidW-1:0]  picked_thread_o,
  output logic             found_o,
  output logic [CoreW-1:0] placed_core_o
);

  localparam int unsigned CW    = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int unsigned SLOTS = CORES * PRIORITY_LEVELS;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned PW    = $clog2(PRIORITY_LEVELS);
  localparam int unsigned LW    = $clog2(THREADS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_PICK1 = 2'd2;
  localparam logic [1:0] S_PICK2 = 2'd3;

  logic [1:0]                 state_q, state_d;
  cmd_t                       cmd_q, cmd_d;
  logic                       empty_q, empty_d;
  logic                       last_q, last_d;
  logic [TidW-1:0]            h_q, h_d;
  logic [PRIORITY_LEVELS-1:0] nonempty_q [CORES];
  logic [PRIORITY_LEVELS-1:0] nonempty_d [CORES];
  logic                       out_valid_q, out_valid_d;
  logic [TidW-1:0]            picked_q, picked_d;
  logic                       found_q, found_d;
  logic [CoreW-1:0]           placed_q, placed_d;

  logic [PRIORITY_LEVELS-1:0] bits_h;
  logic [PrioW-1:0]           pick_prio;
  logic                       pick_empty;
  cmd_t                       cmd_in;
  cmd_t                       cur;
  logic [SW-1:0]              slot;
  logic [CW-1:0]              cur_core;
  logic [PW-1:0]              cur_prio;
  logic                       bit_set;
  logic                       out_free;

  logic                       head_we, tail_we, link_we;
  logic [TidW-1:0]            head_wdata;
  logic [TidW-1:0]            head_rdata, tail_rdata, link_rdata;
  logic [LW-1:0]              link_raddr;

  function automatic logic [SW-1:0] slot_of(logic [CoreW-1:0] c, logic [PrioW-1:0] p);
    logic [7:0] s;
    s = 8'(c) * 8'(PRIORITY_LEVELS) + 8'(p);
    return s[SW-1:0];
  endfunction

  // Highest non-empty level of the core at the queue head.
  always_comb begin
    bits_h    = nonempty_q[q_data_i.core[CW-1:0]];
    pick_prio = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (bits_h[i]) begin
        pick_prio = PrioW'(i);
      end
    end
    pick_empty = ({1'b0, q_data_i.core} >= (CoreW+1)'(CORES)) || (bits_h == '0);
    cmd_in     = q_data_i;
    if (q_data_i.op == OpPick) begin
      cmd_in.prio = pick_prio;
    end
  end

  assign cur      = (state_q == S_IDLE) ? cmd_in : cmd_q;
  assign slot     = slot_of(cur.core, cur.prio);
  assign cur_core = cmd_q.core[CW-1:0];
  assign cur_prio = cmd_q.prio[PW-1:0];
  assign bit_set  = nonempty_q[cur_core][cur_prio];
  assign out_free = !out_valid_q || out_ready_i;

  assign link_raddr = (state_q == S_PICK1) ? head_rdata[LW-1:0] : h_q[LW-1:0];
  assign head_wdata = (state_q == S_ADD) ? cmd_q.tid : link_rdata;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    empty_d     = empty_q;
    last_d      = last_q;
    h_d         = h_q;
    nonempty_d  = nonempty_q;
    out_valid_d = out_valid_q;
    picked_d    = picked_q;
    found_d     = found_q;
    placed_d    = placed_q;
    q_pop_o     = 1'b0;
    head_we     = 1'b0;
    tail_we     = 1'b0;
    link_we     = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = cmd_in;
          empty_d = pick_empty;
          state_d = (q_data_i.op == OpAdd) ? S_ADD : S_PICK1;
        end
      end
      S_ADD: begin
        if (out_free) begin
          if (!cmd_q.drop) begin
            if (bit_set) begin
              link_we = 1'b1;
            end else begin
              head_we = 1'b1;
            end
            tail_we = 1'b1;
            nonempty_d[cur_core][cur_prio] = 1'b1;
          end
          out_valid_d = 1'b1;
          picked_d    = '0;
          found_d     = 1'b0;
          placed_d    = cmd_q.drop ? '0 : cmd_q.core;
          state_d     = S_IDLE;
        end
      end
      S_PICK1: begin
        if (empty_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            picked_d    = '0;
            found_d     = 1'b0;
            placed_d    = cmd_q.core;
            state_d     = S_IDLE;
          end
        end else begin
          h_d     = head_rdata;
          last_d  = (head_rdata == tail_rdata);
          state_d = S_PICK2;
        end
      end
      S_PICK2: begin
        if (out_free) begin
          if (last_q) begin
            nonempty_d[cur_core][cur_prio] = 1'b0;
          end else begin
            head_we = 1'b1;
          end
          out_valid_d = 1'b1;
          picked_d    = h_q;
          found_d     = 1'b1;
          placed_d    = cmd_q.core;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  pprq_ram #(.WIDTH(TidW), .DEPTH(SLOTS)) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(slot),
    .wdata_i(head_wdata),
    .raddr_i(slot),
    .rdata_o(head_rdata)
  );

  pprq_ram #(.WIDTH(TidW), .DEPTH(SLOTS)) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (tail_we),
    .waddr_i(slot),
    .wdata_i(cmd_q.tid),
    .raddr_i(slot),
    .rdata_o(tail_rdata)
  );

  pprq_ram #(.WIDTH(TidW), .DEPTH(THREADS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(tail_rdata[LW-1:0]),
    .wdata_i(cmd_q.tid),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    empty_q  <= empty_d;
    last_q   <= last_d;
    h_q      <= h_d;
    picked_q <= picked_d;
    found_q  <= found_d;
    placed_q <= placed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CORES; c++) begin
        nonempty_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nonempty_q  <= nonempty_d;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign picked_thread_o = picked_q;
  assign found_o         = found_q;
  assign placed_core_o   = placed_q;

endmodule

FILE: design/percore_priority_run_queue.sv
// A request is registered in the command queue, then in the back's command register, and
// its result in the output register; a pick that finds a thread also passes S_PICK2. The
// back takes one command at a time, reading then writing the head, tail and link memories,
// and waits while a result is untaken; a pick reads the link memory only after the head.
// Reset: rst_ni resets the round-robin counter, configuration, non-empty bitmaps and all
// handshake state at once; the memories are not cleared and need no clearing pass.
`include "percore_priority_run_queue_assert.svh"

module percore_priority_run_queue import pprq_pkg::*; #(
  parameter int unsigned CORES           = CoresDef,
  parameter int unsigned PRIORITY_LEVELS = LevelsDef,
  parameter int unsigned THREADS         = ThreadsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port.
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  // Request channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [TidW-1:0]            thread_id_i,
  input  logic signed [PrioReqW-1:0] priority_req_i,
  input  logic signed [AffW-1:0]     affinity_i,
  input  logic                       normal_policy_i,
  input  logic [CoreW-1:0]           core_i,
  // Result channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [TidW-1:0]            picked_thread_o,
  output logic                       found_o,
  output logic [CoreW-1:0]           placed_core_o
);

  // The front classifies each request as it is transferred: it clamps the
  // priority, resolves affinity, round robin and isolation for adds, and
  // pushes a compact command. The back works the memories one command at a
  // time and leaves the result in its output register, so the front keeps
  // taking requests while a result waits to be taken, until the command queue is full.
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_wdata;
  cmd_t q_head;
  logic back_busy;

  pprq_front #(
    .CORES          (CORES),
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .THREADS        (THREADS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .thread_id_i    (thread_id_i),
    .priority_req_i (priority_req_i),
    .affinity_i     (affinity_i),
    .normal_policy_i(normal_policy_i),
    .core_i         (core_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  // Short command queue that decouples the two halves.
  pprq_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  pprq_back #(
    .CORES          (CORES),
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .THREADS        (THREADS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_head),
    .q_pop_o        (q_pop),
    .busy_o         (back_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .picked_thread_o(picked_thread_o),
    .found_o        (found_o),
    .placed_core_o  (placed_core_o)
  );

  // A result without a thread always reports thread zero.
  `PPRQ_ASSERT_IMP(a_notfound_zero, out_valid_o && !found_o, picked_thread_o == '0, "thread without find")
  // A popped thread always comes from an existing core.
  `PPRQ_ASSERT_IMP(a_found_core, out_valid_o && found_o, ({1'b0, placed_core_o} < (CoreW+1)'(CORES)), "found on missing core")
  // A transferred request is waiting in the queue on the next cycle.
  `PPRQ_ASSERT_NEXT(a_push_lands, in_valid_i && in_ready_o, q_valid, "request lost")
  // The back only pops while it is free to start a command.
  `PPRQ_ASSERT_IMP(a_pop_idle, q_pop, q_valid && !back_busy, "pop while busy")

endmodule
